>>> src/pure_pursuit_path_tracker_core_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef PURE_PURSUIT_PATH_TRACKER_CORE_MACROS_SVH
`define PURE_PURSUIT_PATH_TRACKER_CORE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define PPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> src/ppt_pkg.sv
// Shared types, codes and constants of the path tracker.
package ppt_pkg;
    localparam int COORD_W = 30;
    localparam int SPEED_W = 16;
    localparam int HEAD_W  = 16;
    localparam int LDIST_W = 20;
    localparam int LCNT_W  = 9;
    localparam int ATAN_LEN = 24;
    localparam int ZW = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_POSE   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_TRACK = 2'd1,
        ST_FINAL = 2'd2
    } status_t;

    localparam logic CFG_LDIST = 1'b0;
    localparam logic CFG_LCNT  = 1'b1;

    // One pose word passed from the front to the back.
    typedef struct packed {
        logic [COORD_W-1:0] east;
        logic [COORD_W-1:0] north;
        logic [SPEED_W-1:0] speed;
    } pose_t;

    // Arctangent of 2^-i in 2^-16 degree units.
    function automatic logic [ZW-1:0] atan_deg16(input logic [4:0] i);
        logic [ZW-1:0] v;
        begin
            case (i)
                5'd0: v = 32'd2949120;
                5'd1: v = 32'd1740967;
                5'd2: v = 32'd919879;
                5'd3: v = 32'd466945;
                5'd4: v = 32'd234379;
                5'd5: v = 32'd117304;
                5'd6: v = 32'd58666;
                5'd7: v = 32'd29335;
                5'd8: v = 32'd14668;
                5'd9: v = 32'd7334;
                5'd10: v = 32'd3667;
                5'd11: v = 32'd1833;
                5'd12: v = 32'd917;
                5'd13: v = 32'd458;
                5'd14: v = 32'd229;
                5'd15: v = 32'd115;
                5'd16: v = 32'd57;
                5'd17: v = 32'd29;
                5'd18: v = 32'd14;
                5'd19: v = 32'd7;
                5'd20: v = 32'd4;
                5'd21: v = 32'd2;
                5'd22: v = 32'd1;
                default: v = 32'd0;
            endcase
            atan_deg16 = v;
        end
    endfunction
endpackage

>>> src/ppt_cordic.sv
// Iterative vectoring CORDIC that turns an offset vector into a compass heading.
module ppt_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [ppt_pkg::COORD_W:0] east,
    input  logic signed [ppt_pkg::COORD_W:0] north,
    output logic                            done,
    output logic [ppt_pkg::HEAD_W-1:0]      heading
);
    import ppt_pkg::*;

    localparam int XW = COORD_W + 1 + 24 + 2;
    localparam int SW = $clog2(CORDIC_STEPS + 1);
    localparam logic signed [ZW+1:0] FULL = (ZW+2)'(23592960);
    localparam logic signed [ZW+1:0] HALF = (ZW+2)'(11796480);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_ITER = 4'b0010,
        C_WRAP = 4'b0100,
        C_OUT  = 4'b1000
    } cst_t;

    cst_t                 st_reg, st_next;
    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW+1:0] z_reg;
    logic [SW-1:0]        i_reg;
    logic                 zero_reg;
    logic signed [XW-1:0] xs, ys, xi, yi;
    logic [ZW+7:0]        cd;

    // Arithmetic shift is the floor shift for negative values as well.
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign xi = XW'(north) <<< 24;
    assign yi = XW'(east) <<< 24;
    assign cd = ((ZW+8)'(z_reg[ZW-1:0]) * (ZW+8)'(100) + (ZW+8)'(32768)) >> 16;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            C_IDLE: if (start) st_next = C_ITER;
            C_ITER: if (zero_reg || i_reg == SW'(CORDIC_STEPS - 1)) st_next = C_WRAP;
            C_WRAP: if (z_reg >= 0 && z_reg < FULL) st_next = C_OUT;
            C_OUT:  st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= C_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            C_IDLE:
            begin
                i_reg <= '0;
                zero_reg <= (east == 0) && (north == 0);
                if (north < 0)
                begin
                    x_reg <= -xi;
                    y_reg <= -yi;
                    z_reg <= HALF;
                end
                else
                begin
                    x_reg <= xi;
                    y_reg <= yi;
                    z_reg <= '0;
                end
            end
            C_ITER:
            begin
                i_reg <= i_reg + 1'b1;
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + (ZW+2)'(atan_deg16(5'(i_reg)));
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - (ZW+2)'(atan_deg16(5'(i_reg)));
                end
            end
            C_WRAP:
            begin
                if (z_reg < 0)
                    z_reg <= z_reg + FULL;
                else if (z_reg >= FULL)
                    z_reg <= z_reg - FULL;
            end
            default: ;
        endcase
    end

    assign done = (st_reg == C_OUT);
    assign heading = zero_reg ? HEAD_W'(9000) : (cd >= (ZW+8)'(36000) ? '0 : cd[HEAD_W-1:0]);
endmodule

>>> src/ppt_front.sv
// Front end: takes commands, keeps the path store and count, queues pose words.
module ppt_front #(
    parameter int MAX_WAYPOINTS = 256,
    parameter int QD = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    command,
    input  logic [ppt_pkg::COORD_W-1:0]   pos_easting,
    input  logic [ppt_pkg::COORD_W-1:0]   pos_northing,
    input  logic [ppt_pkg::SPEED_W-1:0]   max_speed,
    input  logic                          back_busy,
    input  logic                          q_pop,
    output logic                          q_valid,
    output ppt_pkg::pose_t                q_data,
    output logic [$clog2(MAX_WAYPOINTS+1)-1:0] count,
    input  logic [$clog2(MAX_WAYPOINTS)-1:0]   rd_addr,
    output logic [ppt_pkg::COORD_W-1:0]   rd_east,
    output logic [ppt_pkg::COORD_W-1:0]   rd_north,
    output logic                          clear_tgt
);
    import ppt_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int QW = $clog2(QD);

    logic [COORD_W-1:0] mem_e [MAX_WAYPOINTS];
    logic [COORD_W-1:0] mem_n [MAX_WAYPOINTS];
    pose_t              q_mem [QD];
    logic [QW-1:0]      wp_reg, rp_reg;
    logic [QW:0]        fill_reg;
    logic [CW-1:0]      count_reg;
    logic               acc, is_pose, q_full;

    // Path changes wait until no pose word is queued or running so the back
    // end always sees a stable path.
    assign q_full  = (fill_reg == (QW+1)'(QD));
    assign is_pose = (cmd_t'(command) == CMD_POSE);
    assign full    = is_pose ? q_full : (fill_reg != '0 || back_busy);
    assign acc     = push && !full;
    assign q_valid = (fill_reg != '0);
    assign q_data  = q_mem[rp_reg];
    assign count   = count_reg;
    assign clear_tgt = acc && cmd_t'(command) == CMD_CLEAR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (acc && cmd_t'(command) == CMD_CLEAR)
                count_reg <= '0;
            else if (acc && cmd_t'(command) == CMD_APPEND && count_reg < CW'(MAX_WAYPOINTS))
                count_reg <= count_reg + 1'b1;
            if (acc && is_pose)
                wp_reg <= (wp_reg == QW'(QD - 1)) ? '0 : wp_reg + 1'b1;
            if (q_pop && q_valid)
                rp_reg <= (rp_reg == QW'(QD - 1)) ? '0 : rp_reg + 1'b1;
            fill_reg <= fill_reg + (QW+1)'(acc && is_pose) - (QW+1)'(q_pop && q_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && cmd_t'(command) == CMD_APPEND && count_reg < CW'(MAX_WAYPOINTS))
        begin
            mem_e[count_reg[AW-1:0]] <= pos_easting;
            mem_n[count_reg[AW-1:0]] <= pos_northing;
        end
        if (acc && is_pose)
            q_mem[wp_reg] <= '{east: pos_easting, north: pos_northing, speed: max_speed};
        rd_east  <= mem_e[rd_addr];
        rd_north <= mem_n[rd_addr];
    end
endmodule

>>> src/ppt_back.sv
// Back end: nearest search, end test, lookahead scan and heading for one pose.
module ppt_back #(
    parameter int MAX_WAYPOINTS = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  ppt_pkg::pose_t                q_data,
    output logic                          q_pop,
    output logic                          busy,
    input  logic [$clog2(MAX_WAYPOINTS+1)-1:0] count,
    output logic [$clog2(MAX_WAYPOINTS)-1:0]   rd_addr,
    input  logic [ppt_pkg::COORD_W-1:0]   rd_east,
    input  logic [ppt_pkg::COORD_W-1:0]   rd_north,
    input  logic                          clear_tgt,
    input  logic [ppt_pkg::LDIST_W-1:0]   ldist,
    input  logic [ppt_pkg::LCNT_W-1:0]    lcnt,
    input  logic                          res_free,
    output logic                          res_load,
    output logic [ppt_pkg::HEAD_W-1:0]    res_heading,
    output logic [ppt_pkg::SPEED_W-1:0]   res_speed,
    output logic [7:0]                    res_index,
    output logic [1:0]                    res_status
);
    import ppt_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int DW = COORD_W + 1;
    localparam int SQW = 2 * DW + 1;

    typedef enum logic [11:0] {
        B_IDLE  = 12'b000000000001,
        B_NRD   = 12'b000000000010,
        B_NSQ   = 12'b000000000100,
        B_NCMP  = 12'b000000001000,
        B_EA    = 12'b000000010000,
        B_EB    = 12'b000000100000,
        B_EMUL  = 12'b000001000000,
        B_ECMP  = 12'b000010000000,
        B_LRD   = 12'b000100000000,
        B_LCMP  = 12'b001000000000,
        B_AIM   = 12'b010000000000,
        B_HEAD  = 12'b100000000000
    } bst_t;

    bst_t               st_reg;
    pose_t              p_reg;
    logic [AW-1:0]      tgt_reg, idx_reg, best_reg, aim_reg;
    logic [CW-1:0]      limit_reg;
    logic [SQW-1:0]     best_d_reg, sq_e_reg, sq_n_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, ax_reg, ay_reg, rx_reg, ry_reg;
    logic               first_reg, started_reg;
    logic [1:0]         wait_reg;
    logic [1:0]         status_reg;
    logic [CW:0]        lim_calc;
    logic [CW-1:0]      n;
    logic signed [DW-1:0] dx, dy;
    logic [SQW-1:0]     dsum;
    logic signed [2*DW+1:0] len_reg, dot_reg;
    logic [2*LDIST_W-1:0] lsq;
    logic               c_done;
    logic [HEAD_W-1:0]  c_head;
    logic [LCNT_W-1:0]  lc;

    assign n    = count;
    assign dx   = DW'(rd_east) - DW'(p_reg.east);
    assign dy   = DW'(rd_north) - DW'(p_reg.north);
    assign dsum = sq_e_reg + sq_n_reg;
    assign lsq  = ldist * ldist;
    assign lc   = (lcnt == '0) ? LCNT_W'(1) : lcnt;
    assign lim_calc = (CW+1)'(tgt_reg) + (CW+1)'(lc);
    assign busy = (st_reg != B_IDLE);
    assign q_pop = (st_reg == B_IDLE) && q_valid && res_free;

    ppt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(st_reg == B_HEAD && !started_reg),
        .east(ax_reg), .north(ay_reg), .done(c_done), .heading(c_head)
    );

    always_comb
    begin
        case (st_reg)
            B_EA:    rd_addr = AW'(n - CW'(2));
            B_EB:    rd_addr = AW'(n - CW'(1));
            B_AIM:   rd_addr = aim_reg;
            default: rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            tgt_reg <= '0;
            res_load <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            res_load <= 1'b0;
            if (clear_tgt)
                tgt_reg <= '0;
            case (st_reg)
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (n == '0)
                        begin
                            res_load <= 1'b1;
                            status_reg <= ST_EMPTY;
                        end
                        else if (n == CW'(1))
                        begin
                            tgt_reg <= '0;
                            aim_reg <= '0;
                            status_reg <= ST_FINAL;
                            first_reg <= 1'b1;
                            st_reg <= B_AIM;
                        end
                        else
                        begin
                            if (CW'(tgt_reg) > n - CW'(2))
                            begin
                                tgt_reg <= AW'(n - CW'(2));
                                idx_reg <= AW'(n - CW'(2));
                                best_reg <= AW'(n - CW'(2));
                            end
                            else
                            begin
                                idx_reg <= tgt_reg;
                                best_reg <= tgt_reg;
                            end
                            first_reg <= 1'b1;
                            st_reg <= B_NRD;
                        end
                    end
                end
                B_NRD:
                begin
                    wait_reg <= '0;
                    st_reg <= B_NSQ;
                end
                // Read, difference and square are registered in turn with the address held.
                B_NSQ:
                begin
                    wait_reg <= wait_reg + 1'b1;
                    if (wait_reg == 2'd1)
                        st_reg <= B_NCMP;
                end
                B_NCMP:
                begin
                    if (first_reg || dsum < best_d_reg)
                    begin
                        best_d_reg <= dsum;
                        best_reg <= idx_reg;
                    end
                    first_reg <= 1'b0;
                    if (CW'(idx_reg) + CW'(1) >= n - CW'(1))
                        st_reg <= B_EA;
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        st_reg <= B_NRD;
                    end
                end
                B_EA:
                begin
                    tgt_reg <= best_reg;
                    st_reg <= B_EB;
                end
                B_EB:
                begin
                    // Read data now holds waypoint n-2.
                    rx_reg <= DW'(p_reg.east) - DW'(rd_east);
                    ry_reg <= DW'(p_reg.north) - DW'(rd_north);
                    ax_reg <= -DW'(rd_east);
                    ay_reg <= -DW'(rd_north);
                    st_reg <= B_EMUL;
                end
                B_EMUL:
                begin
                    // ax/ay hold the segment vector after adding waypoint n-1.
                    ax_reg <= ax_reg + DW'(rd_east);
                    ay_reg <= ay_reg + DW'(rd_north);
                    st_reg <= B_ECMP;
                    first_reg <= 1'b1;
                end
                B_ECMP:
                begin
                    if (first_reg)
                    begin
                        len_reg <= (2*DW+2)'(ax_reg * ax_reg) + (2*DW+2)'(ay_reg * ay_reg);
                        dot_reg <= (2*DW+2)'(rx_reg * ax_reg) + (2*DW+2)'(ry_reg * ay_reg);
                        first_reg <= 1'b0;
                    end
                    else
                    begin
                        if (CW'(tgt_reg) >= n - CW'(2) && len_reg > 0 && dot_reg >= len_reg)
                        begin
                            aim_reg <= AW'(n - CW'(1));
                            status_reg <= ST_FINAL;
                            first_reg <= 1'b1;
                            st_reg <= B_AIM;
                        end
                        else
                        begin
                            limit_reg <= (lim_calc > (CW+1)'(n)) ? n : CW'(lim_calc);
                            idx_reg <= tgt_reg;
                            status_reg <= ST_TRACK;
                            wait_reg <= '0;
                            st_reg <= B_LRD;
                        end
                    end
                end
                B_LRD:
                begin
                    wait_reg <= wait_reg + 1'b1;
                    if (wait_reg == 2'd2)
                        st_reg <= B_LCMP;
                end
                B_LCMP:
                begin
                    if ((dsum >= SQW'(lsq)) || (CW'(idx_reg) + CW'(1) >= limit_reg))
                    begin
                        aim_reg <= idx_reg;
                        first_reg <= 1'b1;
                        st_reg <= B_AIM;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        wait_reg <= '0;
                        st_reg <= B_LRD;
                    end
                end
                B_AIM:
                begin
                    first_reg <= ~first_reg;
                    if (!first_reg)
                    begin
                        ax_reg <= dx;
                        ay_reg <= dy;
                        started_reg <= 1'b0;
                        st_reg <= B_HEAD;
                    end
                end
                B_HEAD:
                begin
                    started_reg <= 1'b1;
                    if (started_reg && c_done)
                    begin
                        res_load <= 1'b1;
                        st_reg <= B_IDLE;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            p_reg <= q_data;
        dx_reg <= dx;
        dy_reg <= dy;
        sq_e_reg <= SQW'(dx_reg * dx_reg);
        sq_n_reg <= SQW'(dy_reg * dy_reg);
        if (st_reg == B_HEAD && c_done)
            res_heading <= c_head;
        if (st_reg == B_IDLE && q_pop)
            res_speed <= (n == '0) ? '0 : q_data.speed;
        if (st_reg == B_IDLE && q_pop && n == '0)
            res_heading <= '0;
    end

    assign res_index  = 8'(tgt_reg);
    assign res_status = status_reg;
endmodule

>>> src/pure_pursuit_path_tracker_core.sv
// Top level of the pure pursuit path tracker.
// Channel  | Handshake         | Words
// input    | push / full       | command, pos_easting, pos_northing, max_speed
// result   | pop / empty       | heading, speed, target_index, status
// config   | cfg_we (no stall) | cfg_index, cfg_data
// A pose update runs the nearest search over the waypoints, then the lookahead scan,
// and then the CORDIC iterations for the heading.
// Clear and append wait until no pose update is in flight.
// Reset empties the path, sets the target to 0 and loads the register defaults.
// One result register holds the finished word; a pose update starts only when it is free.
`include "pure_pursuit_path_tracker_core_macros.svh"
module pure_pursuit_path_tracker_core #(
    parameter int MAX_WAYPOINTS = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    command,
    input  logic [ppt_pkg::COORD_W-1:0]   pos_easting,
    input  logic [ppt_pkg::COORD_W-1:0]   pos_northing,
    input  logic [ppt_pkg::SPEED_W-1:0]   max_speed,
    output logic                          empty,
    input  logic                          pop,
    output logic [ppt_pkg::HEAD_W-1:0]    heading,
    output logic [ppt_pkg::SPEED_W-1:0]   speed,
    output logic [7:0]                    target_index,
    output logic [1:0]                    status,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ppt_pkg::LDIST_W-1:0]   cfg_data
);
    import ppt_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);

    logic [LDIST_W-1:0] ldist_reg;
    logic [LCNT_W-1:0]  lcnt_reg;
    logic               q_valid, q_pop, busy, clear_tgt, res_load, full_reg;
    pose_t              q_data;
    logic [CW-1:0]      count;
    logic [AW-1:0]      rd_addr;
    logic [COORD_W-1:0] rd_east, rd_north;
    logic [HEAD_W-1:0]  r_head;
    logic [SPEED_W-1:0] r_speed;
    logic [7:0]         r_index;
    logic [1:0]         r_status;
    logic               res_valid_reg;
    logic [HEAD_W-1:0]  head_out_reg;
    logic [SPEED_W-1:0] speed_out_reg;
    logic [7:0]         index_out_reg;
    logic [1:0]         status_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldist_reg <= LDIST_W'(500);
            lcnt_reg <= LCNT_W'(8);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LDIST)
                ldist_reg <= cfg_data;
            else
                lcnt_reg <= cfg_data[LCNT_W-1:0];
        end
    end

    ppt_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full_reg), .command(command),
        .pos_easting(pos_easting), .pos_northing(pos_northing), .max_speed(max_speed),
        .back_busy(busy || q_pop), .q_pop(q_pop), .q_valid(q_valid), .q_data(q_data),
        .count(count), .rd_addr(rd_addr), .rd_east(rd_east), .rd_north(rd_north),
        .clear_tgt(clear_tgt)
    );
    assign full = full_reg;

    // The result slot counts as taken from the cycle its load is pending.
    ppt_back #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .busy(busy), .count(count), .rd_addr(rd_addr), .rd_east(rd_east),
        .rd_north(rd_north), .clear_tgt(clear_tgt), .ldist(ldist_reg), .lcnt(lcnt_reg),
        .res_free(!res_valid_reg && !res_load), .res_load(res_load), .res_heading(r_head),
        .res_speed(r_speed), .res_index(r_index), .res_status(r_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (pop)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            head_out_reg <= r_head;
            speed_out_reg <= r_speed;
            index_out_reg <= r_index;
            status_out_reg <= r_status;
        end
    end

    assign empty = !res_valid_reg;
    assign heading = head_out_reg;
    assign speed = speed_out_reg;
    assign target_index = index_out_reg;
    assign status = status_out_reg;

    `PPT_ASSERT_IMP(a_no_load_over, clk, rst_n, res_load, !res_valid_reg,
        "result register overwritten")
    `PPT_ASSERT_NEXT(a_load_shows, clk, rst_n, res_load, !empty,
        "loaded result not shown")
    `PPT_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, !busy && !res_valid_reg,
        "pose started while back end busy")
endmodule

>>> tb/pure_pursuit_path_tracker_core_tb.sv
// Self-checking testbench for the pure pursuit path tracker core.
`timescale 1ns / 100ps

module pure_pursuit_path_tracker_core_tb;
    import ppt_pkg::*;

    localparam int COORD_MAX = 1000000000;
    localparam int WATCHDOG_LIMIT = 30000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [15:0] heading;
        logic [15:0] speed;
        logic [7:0]  target;
        status_t     status;
    } steer_word_t;

    class tracker_scoreboard;
        longint      wp_east [256];
        longint      wp_north[256];
        int          wp_count;
        int          target;
        longint      look_dist;
        int          look_count;
        steer_word_t expected_steer[$];
        int          errors;
        longint      atan_units[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                        58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                        229, 115};

        function new();
            wp_count = 0;
            target = 0;
            look_dist = 500;
            look_count = 8;
            errors = 0;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        function void write_reg(logic idx, int value);
            if (idx == CFG_LDIST)
                look_dist = value & 20'hFFFFF;
            else
                look_count = value & 9'h1FF;
        endfunction

        function int compass(longint east, longint north);
            longint x, y, z, xs, ys, cd;
            longint full_turn;
            full_turn = 360 * 65536;
            if (east == 0 && north == 0)
                return 9000;
            x = north * (64'sd1 << 24);
            y = east * (64'sd1 << 24);
            z = 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 180 * 65536;
            end
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_units[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_units[i];
                end
            end
            while (z < 0)
                z = z + full_turn;
            while (z >= full_turn)
                z = z - full_turn;
            cd = (z * 100 + 32768) >>> 16;
            if (cd >= 36000)
                cd = 0;
            return int'(cd);
        endfunction

        function longint range_sq(int idx, longint re, longint rn);
            longint dx, dy;
            dx = wp_east[idx] - re;
            dy = wp_north[idx] - rn;
            return dx * dx + dy * dy;
        endfunction

        // Works out the steering word for one accepted input word, if it makes one.
        function void note_input(cmd_t cmd, longint re, longint rn, logic [15:0] spd);
            steer_word_t w;
            int n, best, lim, pick, lc;
            longint best_d, sx, sy, rx, ry, len, dot, lsq;
            bit final_hit;
            n = wp_count;
            case (cmd)
                CMD_CLEAR:
                begin
                    wp_count = 0;
                    target = 0;
                    return;
                end
                CMD_APPEND:
                begin
                    if (wp_count < 256)
                    begin
                        wp_east[wp_count] = re;
                        wp_north[wp_count] = rn;
                        wp_count++;
                    end
                    return;
                end
                CMD_NONE:
                    return;
                default: ;
            endcase
            w.speed = spd;
            if (n == 0)
            begin
                w.heading = 0;
                w.speed = 0;
                w.target = target[7:0];
                w.status = ST_EMPTY;
            end
            else if (n == 1)
            begin
                target = 0;
                w.heading = compass(wp_east[0] - re, wp_north[0] - rn);
                w.target = target[7:0];
                w.status = ST_FINAL;
            end
            else
            begin
                if (target > n - 2)
                    target = n - 2;
                best = target;
                best_d = -1;
                for (int i = target; i < n - 1; i++)
                begin
                    if (best_d < 0 || range_sq(i, re, rn) < best_d)
                    begin
                        best_d = range_sq(i, re, rn);
                        best = i;
                    end
                end
                target = best;
                final_hit = 0;
                if (target >= n - 2)
                begin
                    sx = wp_east[n-1] - wp_east[n-2];
                    sy = wp_north[n-1] - wp_north[n-2];
                    rx = re - wp_east[n-2];
                    ry = rn - wp_north[n-2];
                    len = sx * sx + sy * sy;
                    dot = rx * sx + ry * sy;
                    final_hit = (len > 0 && dot >= len);
                end
                if (final_hit)
                begin
                    w.heading = compass(wp_east[n-1] - re, wp_north[n-1] - rn);
                    w.status = ST_FINAL;
                end
                else
                begin
                    lsq = look_dist * look_dist;
                    lc = (look_count == 0) ? 1 : look_count;
                    lim = target + lc;
                    if (lim > n)
                        lim = n;
                    pick = lim - 1;
                    for (int i = target; i < lim; i++)
                    begin
                        if (range_sq(i, re, rn) >= lsq)
                        begin
                            pick = i;
                            break;
                        end
                    end
                    w.heading = compass(wp_east[pick] - re, wp_north[pick] - rn);
                    w.status = ST_TRACK;
                end
                w.target = target[7:0];
            end
            expected_steer.push_back(w);
        endfunction

        task check_result(logic [15:0] hd, logic [15:0] sp, logic [7:0] ti, logic [1:0] st);
            steer_word_t w;
            if (expected_steer.size() == 0)
            begin
                $display("[%0t] steering word popped with none expected", $realtime);
                errors++;
                return;
            end
            w = expected_steer.pop_front();
            if (hd !== w.heading)
                report_mismatch("heading", hd, w.heading);
            if (sp !== w.speed)
                report_mismatch("speed", sp, w.speed);
            if (ti !== w.target)
                report_mismatch("target_index", ti, w.target);
            if (st !== w.status)
                report_mismatch("status", st, w.status);
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [1:0]          command;
    logic [COORD_W-1:0]  pos_easting;
    logic [COORD_W-1:0]  pos_northing;
    logic [SPEED_W-1:0]  max_speed;
    logic                empty;
    logic                pop;
    logic [HEAD_W-1:0]   heading;
    logic [SPEED_W-1:0]  speed;
    logic [7:0]          target_index;
    logic [1:0]          status;
    logic                cfg_we;
    logic                cfg_index;
    logic [LDIST_W-1:0]  cfg_data;

    tracker_scoreboard sb;
    bit     rx_hold;
    bit     start_hold;
    bit     rx_burst;
    bit     tx_burst;
    int     idle_cycles;
    longint path_e[$];
    longint path_n[$];

    pure_pursuit_path_tracker_core uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .pos_easting(pos_easting), .pos_northing(pos_northing), .max_speed(max_speed),
        .empty(empty), .pop(pop), .heading(heading), .speed(speed),
        .target_index(target_index), .status(status), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp_coord(longint v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    task offer_word(cmd_t cmd, longint e, longint n, logic [15:0] spd);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        command <= cmd;
        pos_easting <= e[COORD_W-1:0];
        pos_northing <= n[COORD_W-1:0];
        max_speed <= spd;
        do
            @(posedge clk);
        while (full);
        sb.note_input(cmd, e, n, spd);
    endtask

    task pose_at(longint e, longint n);
        offer_word(CMD_POSE, e, n, 16'($urandom));
    endtask

    task append_at(longint e, longint n);
        offer_word(CMD_APPEND, e, n, 16'($urandom));
        path_e.push_back(e);
        path_n.push_back(n);
    endtask

    task clear_path();
        offer_word(CMD_CLEAR, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   16'($urandom));
        path_e.delete();
        path_n.delete();
    endtask

    // Registers may only change once every steering word is out and the core is quiet.
    task write_reg(logic idx, int value);
        @(negedge clk);
        push <= 1'b0;
        while (sb.expected_steer.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[LDIST_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task build_path(int count, int step);
        longint e, n;
        clear_path();
        e = $urandom_range(0, COORD_MAX);
        n = $urandom_range(0, COORD_MAX);
        for (int i = 0; i < count; i++)
        begin
            append_at(e, n);
            e = clamp_coord(e + $urandom_range(0, 2 * step) - step);
            n = clamp_coord(n + $urandom_range(0, 2 * step) - step);
        end
    endtask

    // Rover poses wander along the path so the target walks toward the end.
    task drive_path(int poses, int spread);
        int j;
        for (int k = 0; k < poses; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                offer_word(CMD_NONE, $urandom_range(0, COORD_MAX),
                           $urandom_range(0, COORD_MAX), 16'($urandom));
            if (path_e.size() == 0)
                pose_at($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            else
            begin
                j = (k * path_e.size()) / poses + $urandom_range(0, 1);
                if (j >= path_e.size())
                    j = path_e.size() - 1;
                if ($urandom_range(0, 7) == 0)
                    pose_at($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                else
                    pose_at(clamp_coord(path_e[j] + $urandom_range(0, 2 * spread) - spread),
                            clamp_coord(path_n[j] + $urandom_range(0, 2 * spread) - spread));
            end
        end
    endtask

    initial
    begin
        int step;
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        command = CMD_NONE;
        pos_easting = '0;
        pos_northing = '0;
        max_speed = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_LDIST;
        cfg_data = '0;
        rx_hold = 0;
        start_hold = 0;
        rx_burst = 0;
        tx_burst = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: empty path, single point, degenerate and end-of-path cases.
        pose_at(0, 0);
        pose_at(COORD_MAX, COORD_MAX);
        offer_word(CMD_NONE, COORD_MAX, COORD_MAX, 16'hFFFF);
        append_at(0, 0);
        pose_at(0, 0);
        pose_at(COORD_MAX, COORD_MAX);
        pose_at(0, 1000);
        append_at(0, 0);
        pose_at(10, 10);
        clear_path();
        pose_at(5, 5);
        append_at(COORD_MAX, 0);
        append_at(0, COORD_MAX);
        append_at(500, 500);
        pose_at(COORD_MAX, 0);
        pose_at(600, 600);
        pose_at(0, 0);
        pose_at(100, 100);
        append_at(COORD_MAX, COORD_MAX);
        pose_at(COORD_MAX, COORD_MAX);
        offer_word(CMD_POSE, 536870912, 536870911, 16'h0000);
        offer_word(CMD_POSE, 536870911, 536870912, 16'hFFFF);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(CFG_LDIST, 0); write_reg(CFG_LCNT, 1); end
                1: begin write_reg(CFG_LDIST, 1000000); write_reg(CFG_LCNT, 256); end
                2: begin write_reg(CFG_LDIST, 500); write_reg(CFG_LCNT, 0); end
                3: begin write_reg(CFG_LDIST, 2000); write_reg(CFG_LCNT, 3); end
                4: begin write_reg(CFG_LDIST, 1048575); write_reg(CFG_LCNT, 511); end
                default:
                begin
                    write_reg(CFG_LDIST, $urandom_range(0, 1000000));
                    write_reg(CFG_LCNT, $urandom_range(1, 256));
                end
            endcase
            if (phase == 2)
                start_hold = 1;
            if (phase == 1)
            begin
                // One full store, with an append beyond it that must be dropped.
                build_path(256, 300000);
                append_at(1, 1);
                void'(path_e.pop_back());
                void'(path_n.pop_back());
                drive_path(4, 300000);
            end
            for (int p = 0; p < 6; p++)
            begin
                tx_burst = ($urandom_range(0, 3) == 0);
                step = (p % 3 == 0) ? 300 : (p % 3 == 1) ? 5000 : 400000;
                build_path($urandom_range(1, 12), step);
                drive_path($urandom_range(6, 12), step);
            end
        end
        tx_burst = 0;

        @(negedge clk);
        push <= 1'b0;
        while (sb.expected_steer.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            if (gap > 0 || rx_hold)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
                while (rx_hold)
                    @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            sb.check_result(heading, speed, target_index, status);
        end
    end

    // Long receiver stall so the result register fills and the input backs up.
    initial
    begin
        wait (start_hold);
        @(posedge clk);
        rx_hold = 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 0;
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || cfg_we || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end
endmodule
